// ===== rtl/core/bacc_pkg.sv =====
// Shared constants, command and status types and modular helpers for the completion counter.
`timescale 1ns / 1ps

package bacc_pkg;

  // Number of values tracked, one count per value
  localparam int unsigned MAX_VALUE = 128;
  // Width of a count modulo the prime
  localparam int unsigned WAY_W     = 30;
  // Width of element and bound fields
  localparam int unsigned VAL_W     = 8;
  // Count store address width
  localparam int unsigned ADDR_W    = $clog2(MAX_VALUE);
  // Sweep counter width: holds 0 .. MAX_VALUE + 1
  localparam int unsigned CNT_W     = $clog2(MAX_VALUE + 2);
  // Common width for comparing element values with the sweep position
  localparam int unsigned CMP_W     = (CNT_W > VAL_W) ? CNT_W : VAL_W;

  localparam logic [WAY_W-1:0] WAY_MOD   = WAY_W'(1000000007);
  localparam logic [VAL_W-1:0] CFG_RESET = VAL_W'(100);

  // Controller to datapath commands
  typedef struct packed {
    logic start;     // latch the element, clear the sweep state
    logic issue;     // issue one count read and advance the sweep position
    logic load_out;  // copy the finished sum into the result register
  } bacc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic issue_last;  // the current read is the final one of the sweep
    logic busy;        // update pipeline still holds work
  } bacc_sts_t;

  // Sum of two residues, reduced once
  function automatic logic [WAY_W-1:0] mod_add(input logic [WAY_W-1:0] a,
                                               input logic [WAY_W-1:0] b);
    logic [WAY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, WAY_MOD}) begin
      s = s - {1'b0, WAY_MOD};
    end
    return s[WAY_W-1:0];
  endfunction

endpackage

// ===== rtl/core/bacc_ctrl.sv =====
// Sequencing controller: handshakes, sweep phases and the result slot.
`timescale 1ns / 1ps

module bacc_ctrl import bacc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      last_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bacc_cmd_t cmd_o,
  input  bacc_sts_t sts_i
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSweep = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;

  logic [1:0] state_q, state_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    last_d         = last_q;
    cmd_o.start    = 1'b0;
    cmd_o.issue    = 1'b0;
    cmd_o.load_out = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          cmd_o.start = 1'b1;
          last_d      = last_item_i;
          state_d     = StSweep;
        end
      end
      StSweep: begin
        cmd_o.issue = 1'b1;
        if (sts_i.issue_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (!sts_i.busy) begin
          if (!last_q) begin
            state_d = StIdle;
          end else if (!out_valid_q || out_ready_i) begin
            cmd_o.load_out = 1'b1;
            state_d        = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Result slot: set on load, drop on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/core/bacc_datapath.sv =====
// Count store, neighbour window, modular update pipeline and result accumulator.
`timescale 1ns / 1ps

module bacc_datapath import bacc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [VAL_W-1:0] cfg_wdata_i,
  input  logic [VAL_W-1:0] elem_value_i,
  input  logic             first_item_i,
  output logic [WAY_W-1:0] way_count_o,
  input  bacc_cmd_t        cmd_i,
  output bacc_sts_t        sts_o
);

  // Configuration and per-item latches
  logic [VAL_W-1:0] max_value_q;
  logic [VAL_W-1:0] elem_q;
  logic             first_q;
  logic [CNT_W-1:0] bound;

  // Count store
  logic [WAY_W-1:0] mem_q [MAX_VALUE];
  logic [MAX_VALUE-1:0] vld_q;
  logic [WAY_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic [WAY_W-1:0] rdata;

  // Sweep position and window
  logic [CNT_W-1:0] k_q;
  logic [CNT_W-1:0] rd_k_q;
  logic             rd_act_q;
  logic [WAY_W-1:0] cur_q, left_q;

  // Update pipeline
  logic             s1_go;
  logic             s1_vld_q;
  logic [ADDR_W-1:0] s1_idx_q;
  logic [WAY_W-1:0] s1_part_q;
  logic [WAY_W-1:0] s1_right_q;
  logic             s1_allowed_q;
  logic             allowed;
  logic [WAY_W-1:0] next_count;
  logic             s2_vld_q;
  logic [WAY_W-1:0] s2_next_q;
  logic [WAY_W-1:0] acc_q;
  logic [WAY_W-1:0] way_q;

  // Bound saturates at the store depth
  always_comb begin
    if (32'(max_value_q) > MAX_VALUE) begin
      bound = CNT_W'(MAX_VALUE);
    end else begin
      bound = CNT_W'(max_value_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      max_value_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      elem_q  <= elem_value_i;
      first_q <= first_item_i;
    end
  end

  // Advance the read position; one read per sweep step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= '0;
      rd_k_q   <= '0;
      rd_act_q <= 1'b0;
    end else begin
      rd_act_q <= cmd_i.issue;
      if (cmd_i.start) begin
        k_q <= '0;
      end else if (cmd_i.issue) begin
        k_q    <= k_q + CNT_W'(1);
        rd_k_q <= k_q;
      end
    end
  end

  assign sts_o.issue_last = (k_q == CNT_W'(MAX_VALUE));
  assign sts_o.busy       = rd_act_q || s1_vld_q || s2_vld_q;

  // Registered read; entries never written read as zero
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[k_q[ADDR_W-1:0]];
    rd_vld_q  <= vld_q[k_q[ADDR_W-1:0]];
  end

  assign rdata = rd_vld_q ? rd_data_q : '0;

  // Shift the neighbour window as reads return
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_q  <= '0;
      left_q <= '0;
    end else if (rd_act_q) begin
      cur_q  <= rdata;
      left_q <= cur_q;
    end
  end

  // Stage one: left plus own count, pick right neighbour
  assign s1_go   = rd_act_q && (rd_k_q != '0);
  assign allowed = (rd_k_q <= bound) &&
                   ((elem_q == '0) || (CMP_W'(elem_q) == CMP_W'(rd_k_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s1_idx_q     <= ADDR_W'(rd_k_q - CNT_W'(1));
      s1_part_q    <= mod_add(left_q, cur_q);
      s1_right_q   <= (rd_k_q < bound) ? rdata : '0;
      s1_allowed_q <= allowed;
    end
  end

  // Stage two: finish the new count and write it back
  always_comb begin
    if (!s1_allowed_q) begin
      next_count = '0;
    end else if (first_q) begin
      next_count = WAY_W'(1);
    end else begin
      next_count = mod_add(s1_part_q, s1_right_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      mem_q[s1_idx_q] <= next_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
      if (s1_vld_q) begin
        vld_q[s1_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_next_q <= next_count;
    end
  end

  // Stage three: running sum of the new counts
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (s2_vld_q) begin
      acc_q <= mod_add(acc_q, s2_next_q);
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      way_q <= acc_q;
    end
  end

  assign way_count_o = way_q;

endmodule

// ===== rtl/core/banded_array_completion_counter_core.sv =====
// Top level of the banded array completion counter.
`timescale 1ns / 1ps

// Counts, modulo 1000000007, the ways to complete an array whose neighbours
// differ by at most one, one element per input transfer (0 = unknown). Each
// element sweeps the 128-entry count store through a single read port and a
// three-stage modular update pipeline, one read per count, and takes no new
// element until its sweep has drained. An element flagged last also yields one
// result transfer carrying the sum of the counts; the result waits in an output
// register, and the next element is taken while it waits. The user must write
// max_value through cfg_we_i only while the block is idle; the block does not
// enforce this. Values above the store depth act as the depth.
module banded_array_completion_counter_core import bacc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [VAL_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [VAL_W-1:0] elem_value_i,
  input  logic             first_item_i,
  input  logic             last_item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WAY_W-1:0] way_count_o
);

  bacc_cmd_t cmd;
  bacc_sts_t sts;

  bacc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .last_item_i (last_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  bacc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .elem_value_i (elem_value_i),
    .first_item_i (first_item_i),
    .way_count_o  (way_count_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
